@@ design/mrtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrtt_pkg
// shared types and constants of the rtc timer table
// ----------------------------------------------------------------------------
package mrtt_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int MAX_OUT       = 16;
	localparam int PADDR_W       = 4;

	localparam logic [31:0] RST_MIN_INTERVAL = 32'd5000;
	localparam logic [31:0] RST_MAX_INTERVAL = 32'd600000;
	localparam logic [31:0] NO_INTERVAL      = 32'hffff_ffff;

	// floor(x / 1000) = (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
	localparam logic [28:0] DIV1000_MAGIC = 29'h1062_4dd3;
	localparam int          DIV1000_SHIFT = 38;
	localparam int          QUOT_W        = 23;

	typedef enum logic [1:0] {
		KIND_FREE    = 2'd0,
		KIND_GENERAL = 2'd1,
		KIND_SYSTEM  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REQ_CREATE  = 2'd0,
		REQ_DESTROY = 2'd1,
		REQ_EVENT   = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_REJECTED  = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_NO_SLOT   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_EXPIRY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_DEVICE_OPEN = 2'd0,
		REG_MIN_INTERVAL = 2'd1,
		REG_MAX_INTERVAL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] owner;
		logic [31:0] event_id;
		logic [31:0] period;
		logic [31:0] start;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] timer_id;
		logic [15:0] fire_owner;
		logic        rtc_program;
		logic [31:0] rtc_interval;
		logic        rtc_stop;
	} result_t;

endpackage

@@ design/mrtt_in_if.sv @@
// ----------------------------------------------------------------------------
// mrtt_in_if
// request channel of the rtc timer table
// ----------------------------------------------------------------------------
interface mrtt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] owner;
	logic        owner_valid;
	logic [31:0] event_id;
	logic [31:0] interval_ms;
	logic        is_system;
	logic [31:0] now_seconds;
	logic        timer_fired;

	modport source (output valid, req_type, owner, owner_valid, event_id, interval_ms,
		is_system, now_seconds, timer_fired, input ready);
	modport sink (input valid, req_type, owner, owner_valid, event_id, interval_ms,
		is_system, now_seconds, timer_fired, output ready);
endinterface

@@ design/mrtt_out_if.sv @@
// ----------------------------------------------------------------------------
// mrtt_out_if
// result channel of the rtc timer table
// ----------------------------------------------------------------------------
interface mrtt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] timer_id;
	logic [15:0] fire_owner;
	logic        rtc_program;
	logic [31:0] rtc_interval;
	logic        rtc_stop;
	logic        last;

	modport source (output valid, status, timer_id, fire_owner, rtc_program, rtc_interval,
		rtc_stop, last, input ready);
	modport sink (input valid, status, timer_id, fire_owner, rtc_program, rtc_interval,
		rtc_stop, last, output ready);
endinterface

@@ design/mrtt_ram.sv @@
// ----------------------------------------------------------------------------
// mrtt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mrtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ design/multi_slot_rtc_timer_table.sv @@
// ----------------------------------------------------------------------------
// multi_slot_rtc_timer_table
// table of software timers sharing one rtc countdown timer
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high only while the sequencer is
// idle. Every create, destroy and fired timer event walks the slot table one
// slot at a time through the slot ram: a free slot is skipped in the read
// state, a used slot passes through read and evaluate, and a timer event adds
// a compare step, where one shared divide-by-1000 multiplier feeds the expiry
// compare. A destroy that removes the shortest interval walks the table a
// second time to find the new minimum. Rejected requests skip the walk and go
// straight to the flush state. Results leave through an output register, so
// the next scan may start while the last word waits.
module multi_slot_rtc_timer_table #(
	parameter int TIMER_SLOTS = mrtt_pkg::SLOTS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mrtt_in_if.sink                    in_ch,
	mrtt_out_if.source                 out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mrtt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import mrtt_pkg::*;

	localparam int AW = TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1;
	localparam int IW = $clog2(TIMER_SLOTS + 1);
	localparam int NW = $clog2(MAX_OUT + 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_CMP, S_FLUSH} state_t;
	typedef enum logic [1:0] {OP_CREATE, OP_DESTROY, OP_EVENT, OP_MIN} op_t;

	state_t        state_q;
	op_t           op_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] used_q;
	logic [NW-1:0] nout_q;
	kind_t         kind_q [TIMER_SLOTS];
	logic [AW-1:0] free_q;
	logic          free_found_q;
	logic [31:0]   min_q;
	logic [31:0]   shortest_q;

	logic          dev_open_q;
	logic [31:0]   min_ival_q;
	logic [31:0]   max_ival_q;

	logic [15:0]   owner_q;
	logic [31:0]   ev_q;
	logic [31:0]   ival_q;
	logic          sys_q;
	logic [31:0]   now_q;

	entry_t              ent_q;
	logic [QUOT_W-1:0]   quot_s1;
	result_t             pend_q;
	logic                pend_v_q;
	result_t             out_q;
	logic                out_last_q;
	logic                out_valid_q;

	entry_t        rdata;
	logic          ram_re;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [60:0]   prod;
	logic          due_hit;
	logic          out_free;
	logic          cfg_wr;
	logic [AW-1:0] slot;
	kind_t         want_kind;
	logic          min_ok;

	assign slot      = idx_q[AW-1:0];
	assign want_kind = sys_q ? KIND_SYSTEM : KIND_GENERAL;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign prod      = 61'(rdata.period) * 61'(DIV1000_MAGIC);
	assign due_hit   = ({1'b0, ent_q.start} + 33'(quot_s1)) <= {1'b0, now_q};
	assign min_ok    = (min_q >= min_ival_q) && (min_q <= max_ival_q);
	assign cfg_wr    = psel && penable && pwrite && pready;

	mrtt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TIMER_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(slot),
		.rdata(rdata)
	);

	always_comb begin
		ram_re    = (state_q == S_RD) && (idx_q != IW'(TIMER_SLOTS)) && (kind_q[slot] != KIND_FREE);
		ram_we    = 1'b0;
		ram_waddr = slot;
		ram_wdata = ent_q;
		if (state_q == S_RD && idx_q == IW'(TIMER_SLOTS) && op_q == OP_CREATE && free_found_q) begin
			ram_we    = 1'b1;
			ram_waddr = free_q;
			ram_wdata = '{owner: owner_q, event_id: ev_q, period: ival_q, start: now_q};
		end else if (state_q == S_CMP && due_hit && (!pend_v_q || out_free)) begin
			// restart the expired timer
			ram_we          = 1'b1;
			ram_wdata.start = now_q;
		end
	end

	assign pready            = 1'b1;
	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = out_q.status;
	assign out_ch.timer_id   = out_q.timer_id;
	assign out_ch.fire_owner = out_q.fire_owner;
	assign out_ch.rtc_program  = out_q.rtc_program;
	assign out_ch.rtc_interval = out_q.rtc_interval;
	assign out_ch.rtc_stop   = out_q.rtc_stop;
	assign out_ch.last       = out_last_q;

	always_comb begin
		case (paddr[3:2])
			REG_DEVICE_OPEN:  prdata = {31'd0, dev_open_q};
			REG_MIN_INTERVAL: prdata = min_ival_q;
			REG_MAX_INTERVAL: prdata = max_ival_q;
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_open_q <= 1'b0;
			min_ival_q <= RST_MIN_INTERVAL;
			max_ival_q <= RST_MAX_INTERVAL;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEVICE_OPEN:  dev_open_q <= pwdata[0];
				REG_MIN_INTERVAL: min_ival_q <= pwdata;
				REG_MAX_INTERVAL: max_ival_q <= pwdata;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_CREATE;
			idx_q        <= '0;
			used_q       <= '0;
			nout_q       <= '0;
			free_found_q <= 1'b0;
			shortest_q   <= '0;
			pend_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				kind_q[i] <= KIND_FREE;
			end
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						owner_q      <= in_ch.owner;
						ev_q         <= in_ch.event_id;
						ival_q       <= in_ch.interval_ms;
						sys_q        <= in_ch.is_system;
						now_q        <= in_ch.now_seconds;
						idx_q        <= '0;
						nout_q       <= '0;
						free_found_q <= 1'b0;
						pend_q       <= '0;
						case (in_ch.req_type)
							REQ_CREATE: begin
								if (in_ch.owner == 16'd0 || !dev_open_q || !in_ch.owner_valid) begin
									pend_q.status <= ST_REJECTED;
									pend_v_q      <= 1'b1;
									state_q       <= S_FLUSH;
								end else if (in_ch.interval_ms < min_ival_q) begin
									pend_q.status <= ST_TOO_SHORT;
									pend_v_q      <= 1'b1;
									state_q       <= S_FLUSH;
								end else begin
									op_q    <= OP_CREATE;
									state_q <= S_RD;
								end
							end
							REQ_DESTROY: begin
								if (in_ch.owner == 16'd0 || !in_ch.owner_valid) begin
									pend_q.status <= ST_REJECTED;
									pend_v_q      <= 1'b1;
									state_q       <= S_FLUSH;
								end else begin
									op_q    <= OP_DESTROY;
									state_q <= S_RD;
								end
							end
							REQ_EVENT: begin
								if (in_ch.timer_fired) begin
									op_q    <= OP_EVENT;
									state_q <= S_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (idx_q == IW'(TIMER_SLOTS)) begin
						// end of the table walk
						unique case (op_q)
							OP_CREATE: begin
								pend_v_q <= 1'b1;
								state_q  <= S_FLUSH;
								if (!free_found_q) begin
									pend_q.status <= ST_NO_SLOT;
								end else begin
									kind_q[free_q]  <= want_kind;
									used_q          <= used_q + IW'(1);
									pend_q.status   <= ST_OK;
									pend_q.timer_id <= ev_q;
									if (shortest_q == 32'd0 || ival_q < shortest_q) begin
										shortest_q          <= ival_q;
										pend_q.rtc_program  <= 1'b1;
										pend_q.rtc_interval <= ival_q;
									end
								end
							end
							OP_DESTROY: begin
								pend_q.status <= ST_NOT_FOUND;
								pend_v_q      <= 1'b1;
								state_q       <= S_FLUSH;
								if (used_q == '0) begin
									shortest_q      <= '0;
									pend_q.rtc_stop <= 1'b1;
								end
							end
							OP_MIN: begin
								pend_q.status       <= ST_OK;
								pend_q.rtc_program  <= min_ok;
								pend_q.rtc_interval <= min_ok ? min_q : 32'd0;
								pend_v_q            <= 1'b1;
								state_q             <= S_FLUSH;
								if (used_q == '0) begin
									shortest_q      <= '0;
									pend_q.rtc_stop <= 1'b1;
								end else if (min_ok) begin
									shortest_q <= min_q;
								end
							end
							OP_EVENT: begin
								state_q <= pend_v_q ? S_FLUSH : S_IDLE;
							end
						endcase
					end else if (kind_q[slot] == KIND_FREE) begin
						if (op_q == OP_CREATE && !free_found_q) begin
							free_q       <= slot;
							free_found_q <= 1'b1;
						end
						idx_q <= idx_q + IW'(1);
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					ent_q   <= rdata;
					quot_s1 <= prod[DIV1000_SHIFT +: QUOT_W];
					idx_q   <= idx_q + IW'(1);
					state_q <= S_RD;
					unique case (op_q)
						OP_CREATE: begin
							if (rdata.owner == owner_q && rdata.event_id == ev_q) begin
								pend_q.status   <= ST_OK;
								pend_q.timer_id <= ev_q;
								pend_v_q        <= 1'b1;
								state_q         <= S_FLUSH;
							end
						end
						OP_DESTROY: begin
							if (kind_q[slot] == want_kind && rdata.owner == owner_q &&
								rdata.event_id == ev_q) begin
								kind_q[slot] <= KIND_FREE;
								used_q       <= used_q - IW'(1);
								if (shortest_q == rdata.period) begin
									op_q  <= OP_MIN;
									idx_q <= '0;
									min_q <= NO_INTERVAL;
								end else begin
									pend_q.status <= ST_OK;
									pend_v_q      <= 1'b1;
									state_q       <= S_FLUSH;
									if (used_q == IW'(1)) begin
										shortest_q      <= '0;
										pend_q.rtc_stop <= 1'b1;
									end
								end
							end
						end
						OP_MIN: begin
							if (rdata.period < min_q) begin
								min_q <= rdata.period;
							end
						end
						OP_EVENT: begin
							idx_q   <= idx_q;
							state_q <= S_CMP;
						end
					endcase
				end
				S_CMP: begin
					if (!due_hit) begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_RD;
					end else if (!pend_v_q || out_free) begin
						// the held expiry is not the final one, send it on
						if (pend_v_q) begin
							out_q       <= pend_q;
							out_last_q  <= 1'b0;
							out_valid_q <= 1'b1;
						end
						pend_q     <= '{status: ST_EXPIRY, timer_id: ent_q.event_id,
							fire_owner: ent_q.owner, rtc_program: 1'b0, rtc_interval: 32'd0,
							rtc_stop: 1'b0};
						pend_v_q   <= 1'b1;
						nout_q     <= nout_q + NW'(1);
						idx_q      <= idx_q + IW'(1);
						state_q    <= (nout_q + NW'(1) == NW'(MAX_OUT)) ? S_FLUSH : S_RD;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_q       <= pend_q;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
